/* hw/rtl/idq_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and helper functions of the indexed double-ended queue.
package idq_pkg;

  // Capacity of the list in words.
  localparam int Depth  = 16;
  localparam int WordW  = 32;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW   = $clog2(Depth + 1);
  localparam int SumW   = CntW + 1;
  localparam int PosW   = 5;
  localparam int OutCntW = 5;
  localparam int CmpW   = (CntW > PosW) ? CntW : PosW;
  localparam int ExtW   = (CntW > OutCntW) ? CntW : OutCntW;

  // Request codes.
  localparam logic [3:0] ReqPushBack  = 4'd0;
  localparam logic [3:0] ReqPushFront = 4'd1;
  localparam logic [3:0] ReqPopBack   = 4'd2;
  localparam logic [3:0] ReqPopFront  = 4'd3;
  localparam logic [3:0] ReqReadAt    = 4'd4;
  localparam logic [3:0] ReqReplaceAt = 4'd5;
  localparam logic [3:0] ReqInsertAt  = 4'd6;
  localparam logic [3:0] ReqRemoveAt  = 4'd7;
  localparam logic [3:0] ReqRemoveAll = 4'd8;

  // Status codes.
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;
  localparam logic [1:0] StRange = 2'd3;

  // Sequencer states.
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SExec = 3'd1;
  localparam logic [2:0] SRd   = 3'd2;
  localparam logic [2:0] SWr   = 3'd3;
  localparam logic [2:0] SFin  = 3'd4;

  // Physical slot of a logical index; front plus index stays below twice the depth.
  function automatic logic [AddrW-1:0] slot_of(input logic [AddrW-1:0] front,
                                               input logic [CntW-1:0]  idx);
    logic [SumW-1:0] sum;
    sum = SumW'(front) + SumW'(idx);
    if (sum >= SumW'(Depth)) begin
      sum = sum - SumW'(Depth);
    end
    return sum[AddrW-1:0];
  endfunction

  // Count as reported on the result ports, kept to its low five bits.
  function automatic logic [OutCntW-1:0] out_count(input logic [CntW-1:0] v);
    logic [ExtW-1:0] t;
    t = ExtW'(v);
    return t[OutCntW-1:0];
  endfunction

endpackage

/* hw/rtl/idq_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module idq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/indexed_double_ended_queue.sv */
`timescale 1ns / 1ps
// Top level of the indexed double-ended queue: sequencer, pointers and element RAM.
//
// The block keeps a list of up to idq_pkg::Depth signed 32-bit words in a circular
// RAM addressed from a front pointer. A request word (req_type_i, item_value_i,
// position_i) is taken at a rising edge where start is high and busy is low.
// busy stays high until the result word has been issued, so one request is
// worked on at a time. The result word (read_value_o, status_o, element_count_o,
// removed_count_o) is shown for exactly one cycle with valid_o high; the receiver
// cannot hold it off and must take it in that cycle.
// Pushes, replace and refused or unused requests finish in the execute state;
// pops and read_at pass through the execute and finish states. insert_at,
// remove_at and remove_all walk the stored words through the single RAM read and
// write port, a read state and a write state for each word moved or examined.
// A new request can be accepted in the cycle the result strobe is shown.
// Reset clears the front pointer and the element count, so the list is empty;
// RAM contents are not cleared because a slot is only read after it was written.
// One shared slot adder (front pointer plus logical index, wrapped at the depth) forms
// the RAM addresses but for push_front and pop_front, which address from the front pointer.
module indexed_double_ended_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [3:0]                    req_type_i,
  input  logic signed [31:0]            item_value_i,
  input  logic [4:0]                    position_i,
  output logic                          valid_o,
  output logic signed [31:0]            read_value_o,
  output logic [1:0]                    status_o,
  output logic [4:0]                    element_count_o,
  output logic [4:0]                    removed_count_o
);

  // Sequencer and list state.
  logic [2:0]                   state_q, state_d;
  logic [idq_pkg::AddrW-1:0]    front_q, front_d;
  logic [idq_pkg::CntW-1:0]     count_q, count_d;

  // Latched request.
  logic [3:0]                   req_q;
  logic [idq_pkg::WordW-1:0]    val_q;
  logic [idq_pkg::PosW-1:0]     pos_q;

  // Loop indexes: j walks the source, w the destination of remove_all.
  logic [idq_pkg::CntW-1:0]     j_q, j_d;
  logic [idq_pkg::CntW-1:0]     w_q, w_d;

  // Result word.
  logic                         valid_q, valid_d;
  logic [idq_pkg::WordW-1:0]    rd_q, rd_d;
  logic [1:0]                   st_q, st_d;
  logic [idq_pkg::CntW-1:0]     rem_q, rem_d;

  // RAM port.
  logic                         we;
  logic [idq_pkg::AddrW-1:0]    waddr, raddr;
  logic [idq_pkg::WordW-1:0]    wdata, rdata;

  // Shared slot adder.
  logic [idq_pkg::CntW-1:0]     slot_idx;
  logic [idq_pkg::AddrW-1:0]    slot_addr;

  logic                         accept;
  logic                         full, empty;
  logic [idq_pkg::CmpW-1:0]     pos_ext, cnt_ext;
  logic [idq_pkg::AddrW-1:0]    front_dec, front_inc;

  assign accept    = start && !busy;
  assign busy      = (state_q != idq_pkg::SIdle);
  assign full      = (count_q == idq_pkg::CntW'(idq_pkg::Depth));
  assign empty     = (count_q == '0);
  assign pos_ext   = idq_pkg::CmpW'(pos_q);
  assign cnt_ext   = idq_pkg::CmpW'(count_q);
  assign slot_addr = idq_pkg::slot_of(front_q, slot_idx);

  assign front_dec = (front_q == '0) ? idq_pkg::AddrW'(idq_pkg::Depth - 1)
                                     : front_q - idq_pkg::AddrW'(1);
  assign front_inc = (front_q == idq_pkg::AddrW'(idq_pkg::Depth - 1)) ? '0
                                     : front_q + idq_pkg::AddrW'(1);

  idq_ram #(
    .Width (idq_pkg::WordW),
    .Depth (idq_pkg::Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d  = state_q;
    front_d  = front_q;
    count_d  = count_q;
    j_d      = j_q;
    w_d      = w_q;
    valid_d  = 1'b0;
    rd_d     = rd_q;
    st_d     = st_q;
    rem_d    = rem_q;
    we       = 1'b0;
    wdata    = val_q;
    slot_idx = j_q;
    waddr    = slot_addr;
    raddr    = slot_addr;

    case (state_q)
      idq_pkg::SIdle: begin
        if (accept) begin
          state_d = idq_pkg::SExec;
        end
      end

      idq_pkg::SExec: begin
        // Most requests finish here; set up the plain result first.
        valid_d = 1'b1;
        state_d = idq_pkg::SIdle;
        rd_d    = '0;
        st_d    = idq_pkg::StOk;
        rem_d   = '0;
        case (req_q)
          idq_pkg::ReqPushBack: begin
            slot_idx = count_q;
            if (full) begin
              st_d = idq_pkg::StFull;
            end else begin
              we      = 1'b1;
              count_d = count_q + idq_pkg::CntW'(1);
            end
          end
          idq_pkg::ReqPushFront: begin
            waddr = front_dec;
            if (full) begin
              st_d = idq_pkg::StFull;
            end else begin
              we      = 1'b1;
              front_d = front_dec;
              count_d = count_q + idq_pkg::CntW'(1);
            end
          end
          idq_pkg::ReqPopBack: begin
            slot_idx = count_q - idq_pkg::CntW'(1);
            if (empty) begin
              st_d = idq_pkg::StEmpty;
            end else begin
              valid_d = 1'b0;
              state_d = idq_pkg::SFin;
              count_d = count_q - idq_pkg::CntW'(1);
              rem_d   = idq_pkg::CntW'(1);
            end
          end
          idq_pkg::ReqPopFront: begin
            raddr = front_q;
            if (empty) begin
              st_d = idq_pkg::StEmpty;
            end else begin
              valid_d = 1'b0;
              state_d = idq_pkg::SFin;
              front_d = front_inc;
              count_d = count_q - idq_pkg::CntW'(1);
              rem_d   = idq_pkg::CntW'(1);
            end
          end
          idq_pkg::ReqReadAt: begin
            slot_idx = idq_pkg::CntW'(pos_q);
            if (pos_ext >= cnt_ext) begin
              st_d = idq_pkg::StRange;
            end else begin
              valid_d = 1'b0;
              state_d = idq_pkg::SFin;
            end
          end
          idq_pkg::ReqReplaceAt: begin
            slot_idx = idq_pkg::CntW'(pos_q);
            if (pos_ext >= cnt_ext) begin
              st_d = idq_pkg::StRange;
            end else begin
              we = 1'b1;
            end
          end
          idq_pkg::ReqInsertAt: begin
            if (full) begin
              st_d = idq_pkg::StFull;
            end else if (pos_ext > cnt_ext) begin
              st_d = idq_pkg::StRange;
            end else begin
              valid_d = 1'b0;
              state_d = idq_pkg::SRd;
              j_d     = count_q;
            end
          end
          idq_pkg::ReqRemoveAt: begin
            if (pos_ext >= cnt_ext) begin
              st_d = idq_pkg::StRange;
            end else begin
              valid_d = 1'b0;
              state_d = idq_pkg::SRd;
              j_d     = idq_pkg::CntW'(pos_q);
            end
          end
          idq_pkg::ReqRemoveAll: begin
            valid_d = 1'b0;
            state_d = idq_pkg::SRd;
            j_d     = '0;
            w_d     = '0;
          end
          default: begin
          end
        endcase
      end

      idq_pkg::SRd: begin
        // Either issue the next source read or close out the loop.
        case (req_q)
          idq_pkg::ReqInsertAt: begin
            if (idq_pkg::CmpW'(j_q) > pos_ext) begin
              slot_idx = j_q - idq_pkg::CntW'(1);
              state_d  = idq_pkg::SWr;
            end else begin
              we      = 1'b1;
              count_d = count_q + idq_pkg::CntW'(1);
              valid_d = 1'b1;
              state_d = idq_pkg::SIdle;
            end
          end
          idq_pkg::ReqRemoveAt: begin
            if ((j_q + idq_pkg::CntW'(1)) < count_q) begin
              slot_idx = j_q + idq_pkg::CntW'(1);
              state_d  = idq_pkg::SWr;
            end else begin
              count_d = count_q - idq_pkg::CntW'(1);
              rem_d   = idq_pkg::CntW'(1);
              valid_d = 1'b1;
              state_d = idq_pkg::SIdle;
            end
          end
          default: begin
            // Remove all matches, compacting survivors toward the front.
            if (j_q < count_q) begin
              state_d = idq_pkg::SWr;
            end else begin
              count_d = w_q;
              rem_d   = count_q - w_q;
              valid_d = 1'b1;
              state_d = idq_pkg::SIdle;
            end
          end
        endcase
      end

      idq_pkg::SWr: begin
        wdata   = rdata;
        state_d = idq_pkg::SRd;
        case (req_q)
          idq_pkg::ReqInsertAt: begin
            we  = 1'b1;
            j_d = j_q - idq_pkg::CntW'(1);
          end
          idq_pkg::ReqRemoveAt: begin
            we  = 1'b1;
            j_d = j_q + idq_pkg::CntW'(1);
          end
          default: begin
            slot_idx = w_q;
            j_d      = j_q + idq_pkg::CntW'(1);
            if (rdata != val_q) begin
              we  = 1'b1;
              w_d = w_q + idq_pkg::CntW'(1);
            end
          end
        endcase
      end

      idq_pkg::SFin: begin
        rd_d    = rdata;
        valid_d = 1'b1;
        state_d = idq_pkg::SIdle;
      end

      default: begin
        state_d = idq_pkg::SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= idq_pkg::SIdle;
      front_q <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i;
      val_q <= item_value_i;
      pos_q <= position_i;
    end
    j_q   <= j_d;
    w_q   <= w_d;
    rd_q  <= rd_d;
    st_q  <= st_d;
    rem_q <= rem_d;
  end

  assign valid_o         = valid_q;
  assign read_value_o    = rd_q;
  assign status_o        = st_q;
  assign element_count_o = idq_pkg::out_count(count_q);
  assign removed_count_o = idq_pkg::out_count(rem_q);

endmodule
